@@ src/sscp_pkg.sv @@
// shared constants and types for the serial servo command parser
`timescale 1ns / 1ps

package sscp_pkg;

	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned MagW      = 10;
	localparam int unsigned LoadW     = 16;
	localparam int unsigned ProdW     = MagW + LoadW;

	// register indexes
	localparam logic [CfgIndexW-1:0] REG_PERIOD_LOAD = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_YAW_MIN     = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_YAW_MAX     = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_PITCH_MIN   = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_PITCH_MAX   = 3'd4;

	// register reset values
	localparam logic [15:0] RST_PERIOD_LOAD = 16'd14204;
	localparam logic [7:0]  RST_YAW_MIN     = 8'd20;
	localparam logic [7:0]  RST_YAW_MAX     = 8'd140;
	localparam logic [7:0]  RST_PITCH_MIN   = 8'd50;
	localparam logic [7:0]  RST_PITCH_MAX   = 8'd120;

	// characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P_LO  = 8'h70;
	localparam logic [7:0] CH_P_UP  = 8'h50;
	localparam logic [7:0] CH_Y_LO  = 8'h79;
	localparam logic [7:0] CH_Y_UP  = 8'h59;

	localparam logic [MagW-1:0] MAG_SAT = 10'd999;

	// command kinds
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_PITCH = 2'd1;
	localparam logic [1:0] CMD_YAW   = 2'd2;

	// number phases
	localparam logic [1:0] PH_BLANK = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// divide by 1000 as (p >> 3) / 125 through a reciprocal
	localparam int unsigned    RecipShift = 30;
	localparam int unsigned    RecipW     = 24;
	localparam int unsigned    DivInW     = ProdW - 3;
	localparam logic [RecipW-1:0] RECIP_125 = 24'd8589935;

	typedef struct packed {
		logic [7:0]      tx_byte;
		logic            term;
		logic            set_valid;
		logic            set_channel;
	} beat_info_t;

endpackage

@@ src/serial_servo_command_parser_unit.sv @@
// serial servo command parser: line parser, pulse-width scaling and result emitter
`timescale 1ns / 1ps

// throughput: one byte per cycle while m_axis_tready holds; a line terminator emits two
// output beats (LF, then CR) and stalls the pipe while the CR beat is pending
// pipe: three stages (parse, multiply by load, divide by 1000) and the emitter
// reset: arst_n clears all parse state, pipe valids and the output, and loads the
// limit and load registers with their defaults

module serial_servo_command_parser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // rx_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [23:0]                     m_axis_tdata,  // tx_byte, pulse_width
	output logic [1:0]                      m_axis_tuser,  // set_valid, set_channel
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sscp_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [sscp_pkg::CfgDataW-1:0]   cfg_data
);

	// configuration
	logic [15:0] period_load_q;
	logic [7:0]  yaw_min_q, yaw_max_q, pitch_min_q, pitch_max_q;

	// parse state
	logic                        line_start_q;
	logic [1:0]                  command_kind_q;
	logic [1:0]                  number_phase_q;
	logic                        negative_sign_q;
	logic [sscp_pkg::MagW-1:0]   acc_q;

	logic                        ls_d;
	logic [1:0]                  cmd_d, ph_d;
	logic                        neg_d;
	logic [sscp_pkg::MagW-1:0]   acc_d;
	logic [13:0]                 acc_x10;
	logic                        is_term, is_digit, is_blank, is_sign, cont;
	logic [7:0]                  lo, hi;
	logic                        upd_ok;

	// pipe
	logic                           v_s1, v_s2, v_s3;
	sscp_pkg::beat_info_t           info_s1, info_s2, info_s3;
	logic [sscp_pkg::MagW-1:0]      mag_s1;
	logic [sscp_pkg::ProdW-1:0]     prod_s2;
	logic [15:0]                    pw_s3;
	logic [sscp_pkg::DivInW+sscp_pkg::RecipW-1:0] qprod;
	logic                           rdy1, rdy2, rdy3, load_ok, in_fire, out_fire;

	// emitter
	logic        out_valid_q, pend_q, out_last_q, out_sv_q, out_ch_q;
	logic [7:0]  out_tx_q;
	logic [15:0] out_pw_q;
	logic        cr_sv_q, cr_ch_q;
	logic [15:0] cr_pw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_load_q <= sscp_pkg::RST_PERIOD_LOAD;
			yaw_min_q     <= sscp_pkg::RST_YAW_MIN;
			yaw_max_q     <= sscp_pkg::RST_YAW_MAX;
			pitch_min_q   <= sscp_pkg::RST_PITCH_MIN;
			pitch_max_q   <= sscp_pkg::RST_PITCH_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sscp_pkg::REG_PERIOD_LOAD: period_load_q <= cfg_data;
				sscp_pkg::REG_YAW_MIN:     yaw_min_q     <= cfg_data[7:0];
				sscp_pkg::REG_YAW_MAX:     yaw_max_q     <= cfg_data[7:0];
				sscp_pkg::REG_PITCH_MIN:   pitch_min_q   <= cfg_data[7:0];
				sscp_pkg::REG_PITCH_MAX:   pitch_max_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign load_ok       = !out_valid_q || (m_axis_tready && !pend_q);
	assign rdy3          = load_ok || !v_s3;
	assign rdy2          = rdy3 || !v_s2;
	assign rdy1          = rdy2 || !v_s1;
	assign s_axis_tready = rdy1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = m_axis_tvalid && m_axis_tready;

	// parser
	assign is_term  = (s_axis_tdata == sscp_pkg::CH_LF) || (s_axis_tdata == sscp_pkg::CH_CR);
	assign is_digit = (s_axis_tdata >= sscp_pkg::CH_ZERO) && (s_axis_tdata <= sscp_pkg::CH_NINE);
	assign is_blank = (s_axis_tdata == sscp_pkg::CH_SPACE) || (s_axis_tdata == sscp_pkg::CH_TAB);
	assign is_sign  = (s_axis_tdata == sscp_pkg::CH_MINUS) || (s_axis_tdata == sscp_pkg::CH_PLUS);
	assign acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {10'b0, s_axis_tdata[3:0]};

	always_comb begin
		ls_d  = line_start_q;
		cmd_d = command_kind_q;
		ph_d  = number_phase_q;
		neg_d = negative_sign_q;
		acc_d = acc_q;
		cont  = 1'b1;
		if (is_term) begin
			ls_d  = 1'b1;
			cmd_d = sscp_pkg::CMD_NONE;
			ph_d  = sscp_pkg::PH_BLANK;
			neg_d = 1'b0;
			acc_d = '0;
		end else if (line_start_q) begin
			ls_d = 1'b0;
			if (s_axis_tdata == sscp_pkg::CH_P_LO || s_axis_tdata == sscp_pkg::CH_P_UP) begin
				cmd_d = sscp_pkg::CMD_PITCH;
			end else if (s_axis_tdata == sscp_pkg::CH_Y_LO || s_axis_tdata == sscp_pkg::CH_Y_UP) begin
				cmd_d = sscp_pkg::CMD_YAW;
			end else begin
				cmd_d = sscp_pkg::CMD_NONE;
			end
		end else begin
			if (number_phase_q == sscp_pkg::PH_BLANK) begin
				if (is_blank) begin
					cont = 1'b0;
				end else if (is_sign) begin
					neg_d = (s_axis_tdata == sscp_pkg::CH_MINUS);
					ph_d  = sscp_pkg::PH_SIGN;
					cont  = 1'b0;
				end else begin
					ph_d = sscp_pkg::PH_SIGN;
				end
			end
			if (cont && (ph_d == sscp_pkg::PH_SIGN || ph_d == sscp_pkg::PH_DIGIT)) begin
				if (is_digit) begin
					acc_d = (acc_x10 > {4'b0, sscp_pkg::MAG_SAT}) ? sscp_pkg::MAG_SAT
					                                              : acc_x10[sscp_pkg::MagW-1:0];
					ph_d  = sscp_pkg::PH_DIGIT;
				end else begin
					ph_d = sscp_pkg::PH_DONE;
				end
			end
		end
	end

	// limit check on the finished line
	assign lo = (command_kind_q == sscp_pkg::CMD_PITCH) ? pitch_min_q : yaw_min_q;
	assign hi = (command_kind_q == sscp_pkg::CMD_PITCH) ? pitch_max_q : yaw_max_q;
	assign upd_ok = ((command_kind_q == sscp_pkg::CMD_PITCH) ||
	                 (command_kind_q == sscp_pkg::CMD_YAW)) &&
	                !(negative_sign_q && (acc_q != '0)) &&
	                (acc_q >= {2'b0, lo}) && (acc_q <= {2'b0, hi});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q    <= 1'b1;
			command_kind_q  <= sscp_pkg::CMD_NONE;
			number_phase_q  <= sscp_pkg::PH_BLANK;
			negative_sign_q <= 1'b0;
			acc_q           <= '0;
		end else if (in_fire) begin
			line_start_q    <= ls_d;
			command_kind_q  <= cmd_d;
			number_phase_q  <= ph_d;
			negative_sign_q <= neg_d;
			acc_q           <= acc_d;
		end
	end

	// pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_fire;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	assign qprod = prod_s2[sscp_pkg::ProdW-1:3] * sscp_pkg::RECIP_125;

	// pipe payload
	always_ff @(posedge clk) begin
		if (rdy1) begin
			info_s1.tx_byte     <= s_axis_tdata;
			info_s1.term        <= is_term;
			info_s1.set_valid   <= is_term && upd_ok;
			info_s1.set_channel <= (command_kind_q == sscp_pkg::CMD_YAW);
			mag_s1              <= acc_q;
		end
		if (rdy2) begin
			info_s2 <= info_s1;
			prod_s2 <= {{sscp_pkg::LoadW{1'b0}}, mag_s1} * {{sscp_pkg::MagW{1'b0}}, period_load_q};
		end
		if (rdy3) begin
			info_s3 <= info_s2;
			pw_s3   <= qprod[sscp_pkg::RecipShift +: 16];
		end
	end

	// result emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (pend_q && out_fire) begin
			pend_q <= 1'b0;
		end else if (load_ok) begin
			out_valid_q <= v_s3;
			pend_q      <= v_s3 && info_s3.term;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_fire) begin
			out_tx_q   <= sscp_pkg::CH_CR;
			out_sv_q   <= cr_sv_q;
			out_ch_q   <= cr_ch_q;
			out_pw_q   <= cr_pw_q;
			out_last_q <= 1'b1;
		end else if (load_ok) begin
			out_tx_q   <= info_s3.term ? sscp_pkg::CH_LF : info_s3.tx_byte;
			out_sv_q   <= 1'b0;
			out_ch_q   <= 1'b0;
			out_pw_q   <= '0;
			out_last_q <= !info_s3.term;
			cr_sv_q    <= info_s3.set_valid;
			cr_ch_q    <= info_s3.set_valid && info_s3.set_channel;
			cr_pw_q    <= info_s3.set_valid ? pw_s3 : 16'd0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pw_q, out_tx_q};
	assign m_axis_tuser  = {out_ch_q, out_sv_q};
	assign m_axis_tlast  = out_last_q;

	// checks
	a_pend_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("second terminator beat pending without an output beat");

	a_cr_follows_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && out_fire) |=> (out_valid_q && m_axis_tlast &&
		                          m_axis_tdata[7:0] == sscp_pkg::CH_CR))
		else $error("CR beat did not follow LF");

	a_notlast_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[7:0] == sscp_pkg::CH_LF && pend_q))
		else $error("non-final beat is not the LF of a terminator");

	a_update_on_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		(m_axis_tlast && m_axis_tdata[7:0] == sscp_pkg::CH_CR))
		else $error("servo update outside the CR beat");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_term) |=> (line_start_q && acc_q == '0 &&
		                          command_kind_q == sscp_pkg::CMD_NONE))
		else $error("terminator did not clear the line state");

endmodule
